// ===== design/sao_pkg.sv =====
// Package for the slot allocator: shared widths, opcodes and sequencer states.
// No dependencies.
package sao_pkg;

  localparam int SlotsDefault = 64;
  localparam int DataW        = 32;
  localparam int CountW       = 7;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_GET   = 2'd2,
    OP_SET   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DONE
  } state_e;

endpackage

// ===== design/sao_if.sv =====
// Valid/ready channel interfaces for request and response transfers.
// Depends on sao_pkg.
interface sao_in_if import sao_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [DataW-1:0]  slot_index;
  logic [DataW-1:0]  new_value;

  modport source (output valid, opcode, slot_index, new_value, input ready);
  modport sink   (input valid, opcode, slot_index, new_value, output ready);
endinterface

interface sao_out_if import sao_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  result_data;
  logic              success;
  logic [CountW-1:0] slots_in_use;

  modport source (output valid, result_data, success, slots_in_use, input ready);
  modport sink   (input valid, result_data, success, slots_in_use, output ready);
endinterface

// ===== design/sao_ram.sv =====
// Single write port, single read port RAM with registered read data.
// No dependencies.
module sao_ram #(
  parameter int Depth = 64,
  parameter int Width = 32,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/slot_allocator_with_value_store.sv =====
// Allocate: takes the lowest free slot, found by a scan upward from slot 0;
// the shared slot counter scans one used mark per cycle through the mark RAM read port.
// Free and get: one RAM read, then one check. Set: writes an in-range value when the request is taken.
// One request at a time; the next request is taken once the result is in the output register.
// Reset: clearing pass over every slot of both RAMs with in ready low; count reset to zero.
module slot_allocator_with_value_store import sao_pkg::*; #(
  parameter int SLOTS = SlotsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sao_in_if.sink    in_i,
  sao_out_if.source out_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  state_e            state_q, state_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IW-1:0]     chk_idx_q, chk_idx_d;
  opcode_e           op_q, op_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DataW-1:0]  res_data_q, res_data_d;
  logic              res_ok_q, res_ok_d;

  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  out_data_q;
  logic              out_ok_q;
  logic [CountW-1:0] out_count_q;

  logic              mark_we, mark_wdata, mark_rdata;
  logic [IW-1:0]     mark_waddr, mark_raddr;
  logic              val_we;
  logic [IW-1:0]     val_waddr;
  logic [DataW-1:0]  val_wdata, val_rdata;

  logic in_xfer, in_range, scan_hit, scan_last, out_load;
  opcode_e in_op;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_op      = opcode_e'(in_i.opcode);
  assign in_range   = in_i.slot_index < DataW'(SLOTS);
  assign scan_hit   = chk_vld_q && !mark_rdata;
  assign scan_last  = chk_vld_q && (chk_idx_q == LastIdx);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign mark_raddr = (state_q == ST_SCAN) ? cnt_q : in_i.slot_index[IW-1:0];

  sao_ram #(.Depth(SLOTS), .Width(1), .AddrW(IW)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  sao_ram #(.Depth(SLOTS), .Width(DataW), .AddrW(IW)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (in_i.slot_index[IW-1:0]),
    .rdata_o (val_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LastIdx) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_op)
            OP_ALLOC:       state_d = ST_SCAN;
            OP_FREE, OP_GET: state_d = in_range ? ST_CHECK : ST_DONE;
            OP_SET:         state_d = ST_DONE;
            default:        state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) state_d = ST_DONE;
      end
      ST_CHECK: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    op_d       = op_q;
    idx_d      = idx_q;
    count_d    = count_q;
    res_data_d = res_data_q;
    res_ok_d   = res_ok_q;
    mark_we    = 1'b0;
    mark_waddr = cnt_q;
    mark_wdata = 1'b0;
    val_we     = 1'b0;
    val_waddr  = cnt_q;
    val_wdata  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mark_we = 1'b1;
        val_we  = 1'b1;
        cnt_d   = cnt_q + IW'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_d       = in_op;
          idx_d      = in_i.slot_index[IW-1:0];
          cnt_d      = '0;
          res_data_d = '0;
          res_ok_d   = 1'b0;
          if (in_op == OP_SET && in_range) begin
            val_we    = 1'b1;
            val_waddr = in_i.slot_index[IW-1:0];
            val_wdata = in_i.new_value;
            res_ok_d  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          mark_we    = 1'b1;
          mark_waddr = chk_idx_q;
          mark_wdata = 1'b1;
          count_d    = count_q + CountW'(1);
          res_data_d = DataW'(chk_idx_q);
          res_ok_d   = 1'b1;
        end else if (!scan_last) begin
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_q;
          cnt_d     = cnt_q + IW'(1);
        end
      end
      ST_CHECK: begin
        if (op_q == OP_GET) begin
          res_data_d = val_rdata;
          res_ok_d   = 1'b1;
        end else if (mark_rdata) begin
          mark_we    = 1'b1;
          mark_waddr = idx_q;
          count_d    = count_q - CountW'(1);
          res_ok_d   = 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    op_q       <= op_d;
    idx_q      <= idx_d;
    res_data_q <= res_data_d;
    res_ok_q   <= res_ok_d;
    if (out_load) begin
      out_data_q  <= res_data_q;
      out_ok_q    <= res_ok_q;
      out_count_q <= count_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_data  = out_data_q;
  assign out_o.success      = out_ok_q;
  assign out_o.slots_in_use = out_count_q;

endmodule

// ===== design/sao_checker.sv =====
// Port-level checks for the slot allocator, attached by bind.
// Depends on sao_pkg and the top level.
module sao_checker import sao_pkg::*; #(
  parameter int Slots = SlotsDefault
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [DataW-1:0]  result_data_i,
  input logic              success_i,
  input logic [CountW-1:0] slots_in_use_i
);

  // one request in flight: ready drops after each transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("in ready stayed high after a request transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !success_i) |-> (result_data_i == '0))
    else $error("failed operation returned nonzero data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((Slots >= 128) || (int'(slots_in_use_i) <= Slots)))
    else $error("slots in use exceeds slot count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("response dropped while stalled");

endmodule

bind slot_allocator_with_value_store sao_checker #(.Slots(SLOTS)) u_sao_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_data_i  (out_o.result_data),
  .success_i      (out_o.success),
  .slots_in_use_i (out_o.slots_in_use)
);
